// File: design/csa_pkg.sv
package csa_pkg;

	// register file
	localparam int CFG_W     = 11;
	localparam int THR_W     = 4;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WALL_LIMIT  = 2'd2;

	localparam int GRID_WIDTH_RST  = 64;
	localparam int GRID_HEIGHT_RST = 64;
	localparam int WALL_LIMIT_RST  = 4;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// result queue
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic ACT_CELL  = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;
	localparam logic WALL      = 1'b1;

	typedef struct packed {
		logic action;
		logic cell_in;
	} csa_req_t;

	typedef struct packed {
		logic cell_out;
		logic last_cell;
	} csa_res_t;

	// per-request control handed from the counter stage to the window stage
	typedef struct packed {
		logic emit;
		logic use_pre;
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic last;
	} csa_ctl_t;

endpackage

// File: design/csa_line_store.sv
module csa_line_store #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [1:0]        wr_data,
	output logic [1:0]        rd_word
);

	// bit 1: recent row, bit 0: older row
	logic [1:0] mem [DEPTH];
	logic [1:0] rdata_q;
	logic [1:0] last_wd_q;
	logic       fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		last_wd_q <= wr_data;
	end

	// read and write of the same entry on one edge: take the word being written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (rd_addr == wr_addr);
		end
	end

	assign rd_word = fwd_q ? last_wd_q : rdata_q;

endmodule

// File: design/csa_window.sv
module csa_window (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clear,
	input  logic                    valid_s1,
	input  csa_pkg::csa_ctl_t       ctl_s1,
	input  logic [2:0]              col,
	input  logic [csa_pkg::THR_W-1:0] threshold,
	output logic                    res_push,
	output csa_pkg::csa_res_t       res
);
	import csa_pkg::*;

	logic [8:0]       win_q;
	logic [8:0]       win_next;
	logic [8:0]       win_sel;
	logic [THR_W-1:0] count;
	logic             outside;

	// move one column left, new column enters on the right (top, mid, bottom)
	function automatic logic [8:0] shift_col(input logic [8:0] win, input logic [2:0] c);
		logic [8:0] r;
		for (int i = 0; i < 3; i++) begin
			r[i*3]     = win[i*3+1];
			r[i*3+1]   = win[i*3+2];
			r[i*3+2]   = c[i];
		end
		return r;
	endfunction

	always_comb begin
		win_next = shift_col(win_q, col);
		// end of row: finish the previous cell with a column of walls
		win_sel  = ctl_s1.use_pre ? shift_col(win_q, 3'b111) : win_next;
		count    = '0;
		outside  = 1'b0;
		for (int dr = 0; dr < 3; dr++) begin
			for (int dc = 0; dc < 3; dc++) begin
				outside = (dr == 0 && ctl_s1.top) || (dr == 2 && ctl_s1.bottom) ||
					(dc == 0 && ctl_s1.left) || (dc == 2 && ctl_s1.right);
				if (!(dr == 1 && dc == 1)) begin
					count = count + THR_W'(outside ? WALL : win_sel[dr*3+dc]);
				end
			end
		end
		if (count > threshold) begin
			res.cell_out = WALL;
		end else if (count < threshold) begin
			res.cell_out = ~WALL;
		end else begin
			res.cell_out = win_sel[4];
		end
		res.last_cell = ctl_s1.last;
	end

	assign res_push = valid_s1 && ctl_s1.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (clear) begin
			win_q <= '0;
		end else if (valid_s1) begin
			win_q <= ctl_s1.last ? '0 : win_next;
		end
	end

endmodule

// File: design/csa_res_fifo.sv
module csa_res_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  csa_pkg::csa_res_t             push_data,
	output logic                          res_valid,
	input  logic                          res_ready,
	output csa_pkg::csa_res_t             res_data,
	output logic [csa_pkg::OUT_CNT_W-1:0] count
);
	import csa_pkg::*;

	csa_res_t             mem [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] cnt_q;
	logic                 pop;

	assign pop       = res_valid && res_ready;
	assign res_valid = (cnt_q != '0);
	assign res_data  = mem[rd_ptr_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + OUT_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - OUT_CNT_W'(1);
			end
		end
	end

endmodule

// File: design/cave_smoothing_automaton_pass.sv
// one smoothing pass of the cave automaton over a wall/path grid streamed in raster
// order: each cell becomes wall when more than the wall limit of its eight
// neighbors are walls, path when fewer, and keeps its value on a tie; neighbors
// off the grid count as walls. one request is taken per clock with no bubbles as
// long as the result side keeps up. the result for a cell comes out grid_width + 1
// requests after that cell, so after the last cell the host sends grid_width + 1
// flush requests (any request counts as flush once the grid is in; a flush while
// cells are still due is dropped without a result). last_cell marks the final
// result, after which the block is ready for the next pass. internally a request
// reads the row store, is registered into the 3x3 window and then waits in a
// four-entry result queue; both row stores share one MAX_WIDTH deep, two bit wide
// memory, read per request and written back from the window stage, with a bypass
// when the same column is read on the edge it is written (narrow grids). no
// clearing pass after reset: stale row store bits are always masked as walls. the
// host must write configuration only while idle (unchecked); this restarts the pass
module cave_smoothing_automaton_pass #(
	parameter int MAX_WIDTH  = csa_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = csa_pkg::DEF_MAX_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  csa_pkg::csa_req_t                 req_data,
	output logic                              res_valid,
	input  logic                              res_ready,
	output csa_pkg::csa_res_t                 res_data,
	input  logic                              cfg_we,
	input  logic [csa_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [csa_pkg::CFG_W-1:0]         cfg_data
);
	import csa_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
	localparam int IROW_W = $clog2(MAX_HEIGHT + 2);
	localparam int W_RST  = (GRID_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : GRID_WIDTH_RST;
	localparam int H_RST  = (GRID_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : GRID_HEIGHT_RST;

	// sizes clamped into 1..max when written
	function automatic int unsigned sat_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
		int unsigned r;
		r = int'(v);
		if (r < 1) begin
			r = 1;
		end else if (r > lim) begin
			r = lim;
		end
		return r;
	endfunction

	// configuration
	logic [WID_W-1:0]  w_q;
	logic [HGT_W-1:0]  h_q;
	logic [THR_W-1:0]  thr_q;
	logic              cfg_restart;

	// pass counters
	logic [COL_W-1:0]  in_col_q;
	logic [IROW_W-1:0] in_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;

	// request stage decode
	logic              in_grid;
	logic              ignored;
	logic              cell_bit;
	logic              col_zero;
	logic              col_end;
	logic              ocol_end;
	logic              orow_end;
	logic              launch;
	csa_ctl_t          ctl_d;

	// window stage
	logic              valid_s1;
	csa_ctl_t          ctl_s1;
	logic              bit_s1;
	logic [COL_W-1:0]  addr_s1;
	logic [1:0]        rd_word;

	logic              res_push;
	csa_res_t          res_s1;
	logic [OUT_CNT_W-1:0] fifo_cnt;
	logic              pending;

	// unknown register indexes are dropped and leave the pass alone
	always_comb begin
		case (cfg_index)
			REG_GRID_WIDTH:  cfg_restart = cfg_we;
			REG_GRID_HEIGHT: cfg_restart = cfg_we;
			REG_WALL_LIMIT:  cfg_restart = cfg_we;
			default:         cfg_restart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= WID_W'(W_RST);
			h_q   <= HGT_W'(H_RST);
			thr_q <= THR_W'(WALL_LIMIT_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:  w_q   <= WID_W'(sat_dim(cfg_data, MAX_WIDTH));
				REG_GRID_HEIGHT: h_q   <= HGT_W'(sat_dim(cfg_data, MAX_HEIGHT));
				REG_WALL_LIMIT:  thr_q <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// request stage: the control fields depend on the counters only, not on the request
	always_comb begin
		in_grid  = in_row_q < IROW_W'(h_q);
		ignored  = in_grid && (req_data.action == ACT_FLUSH);
		// once the grid is in, every request pushes walls below the last row
		cell_bit = in_grid ? req_data.cell_in : WALL;
		col_zero = (in_col_q == '0);
		col_end  = (in_col_q == COL_W'(w_q - WID_W'(1)));
		ocol_end = (out_col_q == COL_W'(w_q - WID_W'(1)));
		orow_end = (out_row_q == ROW_W'(h_q - HGT_W'(1)));

		// column zero of a new row closes the last cell of the row two above
		ctl_d.use_pre = col_zero && (in_row_q >= IROW_W'(2));
		ctl_d.emit    = ctl_d.use_pre || (!col_zero && (in_row_q >= IROW_W'(1)));
		ctl_d.top     = (out_row_q == '0);
		ctl_d.bottom  = orow_end;
		ctl_d.left    = (out_col_q == '0);
		ctl_d.right   = ocol_end;
		ctl_d.last    = ctl_d.emit && orow_end && ocol_end;
	end

	// room in the queue for everything still in flight
	assign pending   = valid_s1 && ctl_s1.emit;
	assign req_ready = ((OUT_CNT_W+1)'(fifo_cnt) + (OUT_CNT_W+1)'(pending)) <
		(OUT_CNT_W+1)'(OUT_DEPTH);
	assign launch    = req_valid && req_ready && !ignored;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_restart || (launch && ctl_d.last)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (launch) begin
			in_col_q <= col_end ? '0 : in_col_q + COL_W'(1);
			if (col_end) begin
				in_row_q <= in_row_q + IROW_W'(1);
			end
			if (ctl_d.emit) begin
				out_col_q <= ocol_end ? '0 : out_col_q + COL_W'(1);
				if (ocol_end) begin
					out_row_q <= out_row_q + ROW_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= launch;
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			ctl_s1  <= ctl_d;
			bit_s1  <= cell_bit;
			addr_s1 <= in_col_q;
		end
	end

	// row store: read at request time, written back in the cycle after
	csa_line_store #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (launch),
		.rd_addr (in_col_q),
		.wr_en   (valid_s1),
		.wr_addr (addr_s1),
		.wr_data ({bit_s1, rd_word[1]}),
		.rd_word (rd_word)
	);

	// column into the window: older row on top, new cell at the bottom
	csa_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (cfg_restart),
		.valid_s1  (valid_s1),
		.ctl_s1    (ctl_s1),
		.col       ({bit_s1, rd_word[1], rd_word[0]}),
		.threshold (thr_q),
		.res_push  (res_push),
		.res       (res_s1)
	);

	csa_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_s1),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.count     (fifo_cnt)
	);

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (fifo_cnt < OUT_CNT_W'(OUT_DEPTH)))
		else $error("result pushed into a full queue");

	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ctl_s1.last) |-> (out_col_q == '0 && out_row_q == '0))
		else $error("output position not restarted after the final cell");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		WID_W'(in_col_q) < w_q)
		else $error("input column beyond grid width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		HGT_W'(out_row_q) < h_q)
		else $error("output row beyond grid height");

endmodule

// File: verif/cave_smoothing_automaton_pass_tb.sv
module cave_smoothing_automaton_pass_tb;
	import csa_pkg::*;

	localparam int STORE_DEPTH    = DEF_MAX_WIDTH;
	localparam int MAX_GAP        = 12;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 10;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int ITEM_TARGET    = 1800;
	localparam int MAX_REPORTS    = 10;

	// index with no register behind it, writes must leave the pass alone
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	// 3x3 directed grid, bit i is cell i in raster order
	localparam logic [8:0] DIRECTED_GRID = 9'b011_010_101;

	// predicts the smoothed grid and checks the results against it
	class cave_scoreboard;
		csa_res_t expected_cells[$];
		int fail_count;
		int result_count;

		int width_reg;
		int height_reg;
		int thr_reg;
		bit older_row[STORE_DEPTH];
		bit recent_row[STORE_DEPTH];
		bit [8:0] nbhd;
		int in_col;
		int in_row;
		int out_col;
		int out_row;

		function new();
			width_reg = GRID_WIDTH_RST;
			height_reg = GRID_HEIGHT_RST;
			thr_reg = WALL_LIMIT_RST;
			restart_pass();
		endfunction

		function void restart_pass();
			nbhd = '0;
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		endfunction

		function int grid_cols();
			return (width_reg < 1) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
		endfunction

		function int grid_rows();
			return (height_reg < 1) ? 1 :
				(height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_reg;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_GRID_WIDTH: width_reg = int'(data);
				REG_GRID_HEIGHT: height_reg = int'(data);
				REG_WALL_LIMIT: thr_reg = int'(data[THR_W-1:0]);
				default: return;
			endcase
			restart_pass();
		endfunction

		// window moves one column left, new column enters on the right
		function bit [8:0] shift_column(bit [8:0] win, bit [2:0] column);
			bit [8:0] shifted;
			for (int r = 0; r < 3; r++) begin
				shifted[r*3]   = win[r*3+1];
				shifted[r*3+1] = win[r*3+2];
				shifted[r*3+2] = column[r];
			end
			return shifted;
		endfunction

		function bit smooth_cell(bit [8:0] win, int r, int c, int gw, int gh);
			int walls;
			bit off_grid;
			walls = 0;
			for (int dr = 0; dr < 3; dr++) begin
				for (int dc = 0; dc < 3; dc++) begin
					if (dr == 1 && dc == 1)
						continue;
					off_grid = (dr == 0 && r == 0) || (dr == 2 && r + 1 >= gh) ||
						(dc == 0 && c == 0) || (dc == 2 && c + 1 >= gw);
					walls += off_grid ? 1 : int'(win[dr*3+dc]);
				end
			end
			if (walls > thr_reg)
				return WALL;
			if (walls < thr_reg)
				return !WALL;
			return win[4];
		endfunction

		function void note_request(csa_req_t req);
			int gw;
			int gh;
			int ic;
			int ir;
			bit cell_val;
			bit val;
			bit emit;
			csa_res_t res;
			gw = grid_cols();
			gh = grid_rows();
			if (in_row < gh) begin
				if (req.action == ACT_FLUSH)
					return;
				cell_val = req.cell_in;
			end else begin
				cell_val = WALL;
			end
			ic = in_col;
			ir = in_row;
			emit = 1'b0;
			val = 1'b0;
			if (ic == 0 && ir >= 2) begin
				val = smooth_cell(shift_column(nbhd, 3'b111), out_row, out_col, gw, gh);
				emit = 1'b1;
			end
			nbhd = shift_column(nbhd, {cell_val, recent_row[ic], older_row[ic]});
			older_row[ic] = recent_row[ic];
			recent_row[ic] = cell_val;
			if (ic >= 1 && ir >= 1) begin
				val = smooth_cell(nbhd, out_row, out_col, gw, gh);
				emit = 1'b1;
			end
			ic++;
			if (ic >= gw) begin
				ic = 0;
				ir++;
			end
			in_col = ic;
			in_row = ir;
			if (!emit)
				return;
			res.cell_out = val;
			res.last_cell = (out_row + 1 >= gh) && (out_col + 1 >= gw);
			expected_cells.push_back(res);
			if (res.last_cell) begin
				restart_pass();
			end else begin
				out_col++;
				if (out_col >= gw) begin
					out_col = 0;
					out_row++;
				end
			end
		endfunction

		function void check_result(csa_res_t got);
			csa_res_t want;
			result_count++;
			if (expected_cells.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("result %0d with nothing pending: cell_out=%0b last_cell=%0b",
						result_count, got.cell_out, got.last_cell);
				return;
			end
			want = expected_cells.pop_front();
			if (got.cell_out !== want.cell_out || got.last_cell !== want.last_cell) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("result %0d: expected cell_out=%0b last_cell=%0b, got %0b %0b",
						result_count, want.cell_out, want.last_cell,
						got.cell_out, got.last_cell);
			end
		endfunction

		function int pending();
			return expected_cells.size();
		endfunction

		function int failures();
			return fail_count + expected_cells.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	csa_req_t             req_data;
	logic                 res_valid;
	logic                 res_ready;
	csa_res_t             res_data;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	cave_scoreboard sb = new();

	// knobs and counters for the request and result sides
	bit src_busy     = 1'b1;
	bit sink_busy    = 1'b1;
	bit hold_results = 1'b0;
	int items_sent   = 0;
	int stall_cycles = 0;

	cave_smoothing_automaton_pass #(
		.MAX_WIDTH (DEF_MAX_WIDTH),
		.MAX_HEIGHT(DEF_MAX_HEIGHT)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// both handshakes seen at the rising edge, plus the no-progress watchdog
	always @(posedge clk) begin
		if (req_valid && req_ready)
			sb.note_request(req_data);
		if (res_valid && res_ready)
			sb.check_result(res_data);
		if ((req_valid && req_ready) || (res_valid && res_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("cave_smoothing_automaton_pass regression: fail");
			$finish;
		end
	end

	// result side: random stalls, and one long hold-off when asked for
	initial begin : result_sink
		int gap;
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_results) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_results = 1'b0;
			end
			gap = sink_busy ? $urandom_range(0, MAX_GAP) : 0;
			if (gap > 0) begin
				res_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
		end
	end

	// one request, called and returning at a falling edge
	task automatic send_request(logic act, logic cell_val);
		csa_req_t req;
		int gap;
		req.action = act;
		req.cell_in = cell_val;
		gap = src_busy ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_data <= req;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	// stop offering until every expected result is out, then let the pipe settle
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// leaves cfg_we high, the caller lowers it after the last write
	task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CFG_W-1:0] t);
		wait_drained();
		write_register(REG_GRID_WIDTH, w);
		write_register(REG_GRID_HEIGHT, h);
		write_register(REG_WALL_LIMIT, t);
		cfg_we <= 1'b0;
	endtask

	// one grid at the current size, then width + 1 drain requests unless cut short;
	// stray flushes during input are dropped by the block
	task automatic run_pass(int wall_pct, bit truncate);
		int cols;
		int rows;
		int cells;
		int pause_at;
		cols = sb.grid_cols();
		rows = sb.grid_rows();
		cells = cols * rows;
		if (truncate)
			cells = int'($urandom_range(0, cells - 1));
		pause_at = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, cells)) : -1;
		for (int i = 0; i < cells; i++) begin
			if (i == pause_at)
				wait_drained();
			if ($urandom_range(0, 39) == 0)
				send_request(ACT_FLUSH, 1'($urandom_range(0, 1)));
			send_request(ACT_CELL, $urandom_range(0, 99) < wall_pct);
			items_sent++;
		end
		// a cut-short pass is abandoned, the next register write restarts it
		if (truncate)
			return;
		for (int i = 0; i <= cols; i++) begin
			// an extra cell once the grid is in drains just like a flush
			send_request(($urandom_range(0, 3) == 0) ? ACT_CELL : ACT_FLUSH,
				1'($urandom_range(0, 1)));
			items_sent++;
		end
		// flush after the final result falls into an empty pass and is dropped
		if ($urandom_range(0, 9) == 0)
			send_request(ACT_FLUSH, 1'($urandom_range(0, 1)));
	endtask

	// mostly small grids, a few wider ones, zero saturates to one
	function automatic logic [CFG_W-1:0] random_size();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return '0;
		if (pick < 3)
			return CFG_W'($urandom_range(11, 24));
		return CFG_W'($urandom_range(1, 10));
	endfunction

	// thresholds near the typical four or five rule, sometimes anything up to 15,
	// sometimes with junk above the threshold field
	function automatic logic [CFG_W-1:0] random_threshold();
		logic [CFG_W-1:0] data;
		if ($urandom_range(0, 3) == 0)
			data = CFG_W'($urandom_range(0, 15));
		else
			data = CFG_W'($urandom_range(3, 5));
		if ($urandom_range(0, 7) == 0)
			data[CFG_W-1:THR_W] =
				(CFG_W-THR_W)'($urandom_range(0, (1 << (CFG_W - THR_W)) - 1));
		return data;
	endfunction

	initial begin : stimulus
		int passes;
		int pick;
		int wall_pct;
		req_valid = 1'b0;
		req_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: a 3x3 grid with a stray flush up front, an extra cell
		// among the drain requests and a flush after the pass is over
		configure(11'd3, 11'd3, 11'd4);
		send_request(ACT_FLUSH, WALL);
		for (int i = 0; i < 9; i++)
			send_request(ACT_CELL, DIRECTED_GRID[i]);
		send_request(ACT_FLUSH, 1'b0);
		send_request(ACT_FLUSH, 1'b1);
		send_request(ACT_CELL, 1'b1);
		send_request(ACT_FLUSH, 1'b0);
		send_request(ACT_FLUSH, 1'b1);

		// zero sizes saturate to a single cell, eight outside walls tie at eight
		configure(11'd0, 11'd0, 11'd8);
		send_request(ACT_CELL, 1'b0);
		send_request(ACT_FLUSH, 1'b0);
		send_request(ACT_CELL, 1'b0);

		// threshold above eight turns every cell to path
		configure(11'd1, 11'd1, 11'd9);
		send_request(ACT_CELL, 1'b1);
		send_request(ACT_FLUSH, 1'b1);
		send_request(ACT_FLUSH, 1'b0);

		// write to the spare index, the next pass must be unaffected
		wait_drained();
		write_register(REG_SPARE, '1);
		cfg_we <= 1'b0;
		send_request(ACT_CELL, 1'b1);
		send_request(ACT_FLUSH, 1'b0);
		send_request(ACT_FLUSH, 1'b1);

		// result side holds off for a long stretch while requests keep coming
		src_busy = 1'b0;
		sink_busy = 1'b1;
		configure(11'd8, 11'd6, 11'd4);
		hold_results = 1'b1;
		run_pass(50, 1'b0);

		// over-tall grid saturates to the full height in a single column
		configure(11'd1, 11'd2047, 11'd15);
		run_pass(50, 1'b0);

		// random phases: new setting, a few passes, sometimes one cut short
		while (items_sent < ITEM_TARGET) begin
			src_busy = $urandom_range(0, 3) != 0;
			sink_busy = $urandom_range(0, 3) != 0;
			configure(random_size(), random_size(), random_threshold());
			passes = $urandom_range(1, 3);
			for (int p = 0; p < passes; p++) begin
				pick = $urandom_range(0, 9);
				wall_pct = (pick == 0) ? 0 : (pick == 1) ? 100 : $urandom_range(20, 80);
				run_pass(wall_pct, (p == passes - 1) && ($urandom_range(0, 7) == 0));
			end
		end

		wait_drained();
		if (sb.failures() == 0)
			$display("cave_smoothing_automaton_pass regression: pass");
		else
			$display("cave_smoothing_automaton_pass regression: fail");
		$finish;
	end

endmodule

// File: cave_smoothing_automaton_pass.f
design/csa_pkg.sv
design/csa_line_store.sv
design/csa_window.sv
design/csa_res_fifo.sv
design/cave_smoothing_automaton_pass.sv
verif/cave_smoothing_automaton_pass_tb.sv
